@@ hdl/strided_tensor_copy_address_gen_unit_macros.svh @@
// assertion macros for the strided tensor copy address generator checker
`ifndef STRIDED_TENSOR_COPY_ADDRESS_GEN_UNIT_MACROS_SVH
`define STRIDED_TENSOR_COPY_ADDRESS_GEN_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define STCAG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define STCAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/stcag_pkg.sv @@
// shared constants and types of the strided tensor copy address generator
`timescale 1ns / 1ps
`default_nettype none

package stcag_pkg;

  localparam int RANK_W    = 4;
  localparam int ESIZE_W   = 2;
  localparam int DIM_W     = 3;
  localparam int STRIDE_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_DESC = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RANK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_BASE       = 2'd3;

  typedef struct packed {
    logic             fire;
    logic             func;
    logic [DIM_W-1:0] dim_index;
  } walk_cmd_t;

endpackage

`default_nettype wire

@@ hdl/stcag_walk.sv @@
// configuration registers, dimension tables and odometer counters
`timescale 1ns / 1ps
`default_nettype none

module stcag_walk #(
  parameter int MAX_RANK    = 8,
  parameter int EXTENT_BITS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stcag_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ADDR_BITS-1:0]                cfg_data_i,
  input  stcag_pkg::walk_cmd_t                cmd_i,
  input  logic [EXTENT_BITS-1:0]              extent_i,
  input  logic [stcag_pkg::STRIDE_W-1:0]      src_stride_i,
  input  logic [stcag_pkg::STRIDE_W-1:0]      dst_stride_i,
  output logic [EXTENT_BITS-1:0]              cnt_o        [MAX_RANK],
  output logic [stcag_pkg::STRIDE_W-1:0]      src_stride_o [MAX_RANK],
  output logic [stcag_pkg::STRIDE_W-1:0]      dst_stride_o [MAX_RANK],
  output logic [MAX_RANK-1:0]                 lane_on_o,
  output logic [stcag_pkg::ESIZE_W-1:0]       elem_size_o,
  output logic [ADDR_BITS-1:0]                src_base_o,
  output logic [ADDR_BITS-1:0]                dst_base_o,
  output logic                                last_o
);

  logic [stcag_pkg::RANK_W-1:0]   rank_q;
  logic [stcag_pkg::ESIZE_W-1:0]  esize_q;
  logic [ADDR_BITS-1:0]           src_base_q;
  logic [ADDR_BITS-1:0]           dst_base_q;
  logic [EXTENT_BITS-1:0]         ext_q  [MAX_RANK];
  logic [stcag_pkg::STRIDE_W-1:0] sstr_q [MAX_RANK];
  logic [stcag_pkg::STRIDE_W-1:0] dstr_q [MAX_RANK];
  logic [EXTENT_BITS-1:0]         cnt_q  [MAX_RANK];
  logic [EXTENT_BITS-1:0]         cnt_d  [MAX_RANK];
  logic [MAX_RANK-1:0]            lane_on;
  logic [MAX_RANK-1:0]            fin;
  logic [MAX_RANK-1:0]            inner_fin;
  logic                           last;

  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      lane_on[d] = (d == 0) || (int'(rank_q) > d);
      fin[d]     = ({1'b0, cnt_q[d]} + (EXTENT_BITS + 1)'(1)) >= {1'b0, ext_q[d]};
    end
    for (int d = 0; d < MAX_RANK; d++) begin
      inner_fin[d] = 1'b1;
      for (int k = d + 1; k < MAX_RANK; k++) begin
        inner_fin[d] = inner_fin[d] && (!lane_on[k] || fin[k]);
      end
    end
    last = &(~lane_on | fin);
    for (int d = 0; d < MAX_RANK; d++) begin
      cnt_d[d] = cnt_q[d];
      if (last) begin
        cnt_d[d] = '0;
      end else if (lane_on[d] && inner_fin[d]) begin
        cnt_d[d] = fin[d] ? '0 : cnt_q[d] + EXTENT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q     <= stcag_pkg::RANK_W'(1);
      esize_q    <= stcag_pkg::ESIZE_W'(2);
      src_base_q <= '0;
      dst_base_q <= '0;
      for (int d = 0; d < MAX_RANK; d++) begin
        ext_q[d]  <= EXTENT_BITS'(1);
        sstr_q[d] <= '0;
        dstr_q[d] <= '0;
        cnt_q[d]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          stcag_pkg::CFG_ACTIVE_RANK:    rank_q     <= cfg_data_i[stcag_pkg::RANK_W-1:0];
          stcag_pkg::CFG_ELEM_SIZE_LOG2: esize_q    <= cfg_data_i[stcag_pkg::ESIZE_W-1:0];
          stcag_pkg::CFG_SRC_BASE:       src_base_q <= cfg_data_i;
          stcag_pkg::CFG_DST_BASE:       dst_base_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.fire) begin
        if (cmd_i.func == stcag_pkg::FUNC_STEP) begin
          cnt_q <= cnt_d;
        end else begin
          for (int d = 0; d < MAX_RANK; d++) begin
            if (cmd_i.dim_index == stcag_pkg::DIM_W'(d)) begin
              ext_q[d]  <= extent_i;
              sstr_q[d] <= src_stride_i;
              dstr_q[d] <= dst_stride_i;
            end
          end
        end
      end
    end
  end

  assign cnt_o        = cnt_q;
  assign src_stride_o = sstr_q;
  assign dst_stride_o = dstr_q;
  assign lane_on_o    = lane_on;
  assign elem_size_o  = esize_q;
  assign src_base_o   = src_base_q;
  assign dst_base_o   = dst_base_q;
  assign last_o       = last;

endmodule

`default_nettype wire

@@ hdl/stcag_addr.sv @@
// address datapath: snapshot, per-dimension products, registered adder tree, base add
`timescale 1ns / 1ps
`default_nettype none

module stcag_addr #(
  parameter int MAX_RANK    = 8,
  parameter int EXTENT_BITS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                            clk_i,
  input  logic [$clog2(MAX_RANK)+2:0]     stage_en_i,
  input  logic [EXTENT_BITS-1:0]          cnt_i    [MAX_RANK],
  input  logic [stcag_pkg::STRIDE_W-1:0]  stride_i [MAX_RANK],
  input  logic [MAX_RANK-1:0]             lane_on_i,
  input  logic [stcag_pkg::ESIZE_W-1:0]   elem_size_i,
  input  logic [ADDR_BITS-1:0]            base_i,
  output logic [ADDR_BITS-1:0]            addr_o,
  output logic                            ovf_o
);

  localparam int Levels = $clog2(MAX_RANK);
  localparam int Lanes  = 1 << Levels;
  localparam int ProdW  = EXTENT_BITS + stcag_pkg::STRIDE_W;
  localparam int SumW   = ProdW + Levels;
  localparam int ShW    = SumW + (1 << stcag_pkg::ESIZE_W) - 1;
  localparam int FullW  = ((ShW > ADDR_BITS) ? ShW : ADDR_BITS) + 1;
  localparam int OutSt  = Levels + 2;

  logic [SumW-1:0]      node_q [2*Lanes-1];
  logic [FullW-1:0]     full;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 ovf_q;

  for (genvar d = 0; d < Lanes; d++) begin : g_lane
    if (d < MAX_RANK) begin : g_used
      logic [EXTENT_BITS-1:0]         cnt_q;
      logic [stcag_pkg::STRIDE_W-1:0] stride_q;
      always_ff @(posedge clk_i) begin
        if (stage_en_i[0]) begin
          cnt_q    <= cnt_i[d];
          stride_q <= stride_i[d];
        end
      end
      always_ff @(posedge clk_i) begin
        if (stage_en_i[1]) begin
          node_q[Lanes-1+d] <= lane_on_i[d] ?
                               SumW'(ProdW'(cnt_q) * ProdW'(stride_q)) : '0;
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        if (stage_en_i[1]) begin
          node_q[Lanes-1+d] <= '0;
        end
      end
    end
  end

  for (genvar n = 0; n < Lanes - 1; n++) begin : g_node
    localparam int Depth = $clog2(n + 2) - 1;
    always_ff @(posedge clk_i) begin
      if (stage_en_i[1+Levels-Depth]) begin
        node_q[n] <= node_q[2*n+1] + node_q[2*n+2];
      end
    end
  end

  assign full = (FullW'(node_q[0]) << elem_size_i) + FullW'(base_i);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[OutSt]) begin
      addr_q <= full[ADDR_BITS-1:0];
      ovf_q  <= |full[FullW-1:ADDR_BITS];
    end
  end

  assign addr_o = addr_q;
  assign ovf_o  = ovf_q;

endmodule

`default_nettype wire

@@ hdl/strided_tensor_copy_address_gen_unit.sv @@
// Strided tensor copy address generator: walks up to MAX_RANK dimensions in row-major
// order and issues one source/destination byte address pair per step beat. Descriptor
// beats (func 0) load one dimension's extent and strides and give no result; step beats
// (func 1) give one result each. While the result side does not stall, the block
// takes one beat per cycle, so a pair can leave every cycle. A step beat passes the
// input register, the counter snapshot, one multiply stage, one adder stage per tree
// level and the base-add result register, in that order. The odometer advances in the
// same cycle the beat leaves the input register, so back-to-back steps need no bubbles.
// Configuration writes are to be made only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module strided_tensor_copy_address_gen_unit #(
  parameter int MAX_RANK    = 8,
  parameter int EXTENT_BITS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stcag_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_BITS-1:0]            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_func_i,
  input  logic [stcag_pkg::DIM_W-1:0]     in_dim_index_i,
  input  logic [EXTENT_BITS-1:0]          in_extent_i,
  input  logic [stcag_pkg::STRIDE_W-1:0]  in_src_stride_i,
  input  logic [stcag_pkg::STRIDE_W-1:0]  in_dst_stride_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ADDR_BITS-1:0]            out_src_addr_o,
  output logic [ADDR_BITS-1:0]            out_dst_addr_o,
  output logic                            out_last_o,
  output logic                            out_overflow_o
);

  localparam int Levels    = $clog2(MAX_RANK);
  localparam int NumStages = Levels + 4;

  logic [NumStages-1:0]           vld_q;
  logic [NumStages-1:0]           stage_en;
  logic [NumStages-1:1]           last_q;
  logic                           func_q;
  logic [stcag_pkg::DIM_W-1:0]    dim_q;
  logic [EXTENT_BITS-1:0]         extent_q;
  logic [stcag_pkg::STRIDE_W-1:0] src_stride_q;
  logic [stcag_pkg::STRIDE_W-1:0] dst_stride_q;
  stcag_pkg::walk_cmd_t           cmd;

  logic [EXTENT_BITS-1:0]         cnt        [MAX_RANK];
  logic [stcag_pkg::STRIDE_W-1:0] src_stride [MAX_RANK];
  logic [stcag_pkg::STRIDE_W-1:0] dst_stride [MAX_RANK];
  logic [MAX_RANK-1:0]            lane_on;
  logic [stcag_pkg::ESIZE_W-1:0]  elem_size;
  logic [ADDR_BITS-1:0]           src_base;
  logic [ADDR_BITS-1:0]           dst_base;
  logic                           walk_last;
  logic                           src_ovf;
  logic                           dst_ovf;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    stage_en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  assign in_stall_o = !stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stage_en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      if (stage_en[1]) begin
        vld_q[1] <= vld_q[0] && (func_q == stcag_pkg::FUNC_STEP);
      end
      for (int k = 2; k < NumStages; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0] && in_valid_i) begin
      func_q       <= in_func_i;
      dim_q        <= in_dim_index_i;
      extent_q     <= in_extent_i;
      src_stride_q <= in_src_stride_i;
      dst_stride_q <= in_dst_stride_i;
    end
    if (stage_en[1]) begin
      last_q[1] <= walk_last;
    end
    for (int k = 2; k < NumStages; k++) begin
      if (stage_en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign cmd = '{fire: vld_q[0] && stage_en[1], func: func_q, dim_index: dim_q};

  stcag_walk #(
    .MAX_RANK    (MAX_RANK),
    .EXTENT_BITS (EXTENT_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .extent_i     (extent_q),
    .src_stride_i (src_stride_q),
    .dst_stride_i (dst_stride_q),
    .cnt_o        (cnt),
    .src_stride_o (src_stride),
    .dst_stride_o (dst_stride),
    .lane_on_o    (lane_on),
    .elem_size_o  (elem_size),
    .src_base_o   (src_base),
    .dst_base_o   (dst_base),
    .last_o       (walk_last)
  );

  stcag_addr #(
    .MAX_RANK    (MAX_RANK),
    .EXTENT_BITS (EXTENT_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_src_addr (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en[NumStages-1:1]),
    .cnt_i       (cnt),
    .stride_i    (src_stride),
    .lane_on_i   (lane_on),
    .elem_size_i (elem_size),
    .base_i      (src_base),
    .addr_o      (out_src_addr_o),
    .ovf_o       (src_ovf)
  );

  stcag_addr #(
    .MAX_RANK    (MAX_RANK),
    .EXTENT_BITS (EXTENT_BITS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dst_addr (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en[NumStages-1:1]),
    .cnt_i       (cnt),
    .stride_i    (dst_stride),
    .lane_on_i   (lane_on),
    .elem_size_i (elem_size),
    .base_i      (dst_base),
    .addr_o      (out_dst_addr_o),
    .ovf_o       (dst_ovf)
  );

  assign out_valid_o    = vld_q[NumStages-1];
  assign out_last_o     = last_q[NumStages-1];
  assign out_overflow_o = src_ovf | dst_ovf;

endmodule

`default_nettype wire

@@ hdl/stcag_checker.sv @@
// port-level assertion checker for the strided tensor copy address generator
`timescale 1ns / 1ps
`default_nettype none

`include "strided_tensor_copy_address_gen_unit_macros.svh"

module stcag_checker #(
  parameter int ADDR_BITS = 48
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [ADDR_BITS-1:0] out_src_addr_o,
  input logic [ADDR_BITS-1:0] out_dst_addr_o,
  input logic                 out_last_o,
  input logic                 out_overflow_o
);

  // a held result beat keeps its payload
  `STCAG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_src_addr_o) && $stable(out_dst_addr_o) && $stable(out_last_o) && $stable(out_overflow_o), "result beat changed while stalled")

  // input backpressure only when the result side is full and stalled
  `STCAG_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without a stalled result")

  // a full pipeline stays full until the result side moves
  `STCAG_ASSERT_NEXT(a_stall_keep, in_stall_o, !out_stall_i || in_stall_o, "input stall dropped while result side still stalled")

endmodule

bind strided_tensor_copy_address_gen_unit stcag_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_stcag_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_src_addr_o (out_src_addr_o),
  .out_dst_addr_o (out_dst_addr_o),
  .out_last_o     (out_last_o),
  .out_overflow_o (out_overflow_o)
);

`default_nettype wire

@@ sim/tb_strided_tensor_copy_address_gen_unit.sv @@
// testbench for the strided tensor copy address generator: directed and random walks
`timescale 1ns / 1ps

module tb_strided_tensor_copy_address_gen_unit;

  localparam int MAX_RANK     = 8;
  localparam int EXT_W        = 16;
  localparam int ADDR_W       = 48;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BEATS = 850;
  localparam int WALK_BUDGET  = 96;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              last;
    logic              ovf;
  } addr_pair_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [stcag_pkg::CFG_IDX_W-1:0]   cfg_idx = stcag_pkg::CFG_ACTIVE_RANK;
  logic [ADDR_W-1:0]                 cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_func = stcag_pkg::FUNC_DESC;
  logic [stcag_pkg::DIM_W-1:0]       in_dim_index = '0;
  logic [EXT_W-1:0]                  in_extent = '0;
  logic [stcag_pkg::STRIDE_W-1:0]    in_src_stride = '0;
  logic [stcag_pkg::STRIDE_W-1:0]    in_dst_stride = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [ADDR_W-1:0]                 out_src_addr;
  logic [ADDR_W-1:0]                 out_dst_addr;
  logic                              out_last;
  logic                              out_overflow;

  // walker copy: tables, odometer and registers
  logic [EXT_W-1:0]                  extent_tab [MAX_RANK];
  logic [stcag_pkg::STRIDE_W-1:0]    src_stride_tab [MAX_RANK];
  logic [stcag_pkg::STRIDE_W-1:0]    dst_stride_tab [MAX_RANK];
  logic [EXT_W-1:0]                  walk_idx [MAX_RANK];
  logic [stcag_pkg::RANK_W-1:0]      rank_reg = 4'd1;
  logic [stcag_pkg::ESIZE_W-1:0]     esize_reg = 2'd2;
  logic [ADDR_W-1:0]                 src_base_reg = '0;
  logic [ADDR_W-1:0]                 dst_base_reg = '0;

  addr_pair_t pending_pairs[$];
  int         fails = 0;
  int         beats_sent = 0;
  int         stall_left = 0;
  bit         gap_en = 1'b1;
  bit         stall_en = 1'b1;

  strided_tensor_copy_address_gen_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .in_func_i       (in_func),
    .in_dim_index_i  (in_dim_index),
    .in_extent_i     (in_extent),
    .in_src_stride_i (in_src_stride),
    .in_dst_stride_i (in_dst_stride),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_src_addr_o  (out_src_addr),
    .out_dst_addr_o  (out_dst_addr),
    .out_last_o      (out_last),
    .out_overflow_o  (out_overflow)
  );

  always #4 clk = ~clk;

  initial begin
    for (int d = 0; d < MAX_RANK; d++) begin
      extent_tab[d]     = 16'd1;
      src_stride_tab[d] = '0;
      dst_stride_tab[d] = '0;
      walk_idx[d]       = '0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return {36'd0, w[11:0]};
      default: return w[ADDR_W-1:0];
    endcase
  endfunction

  function automatic logic [stcag_pkg::STRIDE_W-1:0] pick_stride();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return {28'd0, w[3:0]};
      default: return w;
    endcase
  endfunction

  function automatic logic [stcag_pkg::RANK_W-1:0] pick_rank();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return stcag_pkg::RANK_W'(0);
    if (r == 1) return stcag_pkg::RANK_W'($urandom_range(MAX_RANK + 1, 15));
    return stcag_pkg::RANK_W'($urandom_range(1, MAX_RANK));
  endfunction

  function automatic int rank_used();
    if (rank_reg == 0) return 1;
    if (rank_reg > MAX_RANK) return MAX_RANK;
    return int'(rank_reg);
  endfunction

  function automatic bit at_final(int d);
    int ext;
    ext = (extent_tab[d] == 0) ? 1 : int'(extent_tab[d]);
    return (int'(walk_idx[d]) + 1) >= ext;
  endfunction

  // updates the walker for one accepted beat and queues the address pair of a step
  task automatic walk_beat(input logic func, input logic [stcag_pkg::DIM_W-1:0] dim,
                           input logic [EXT_W-1:0] ext,
                           input logic [stcag_pkg::STRIDE_W-1:0] ss,
                           input logic [stcag_pkg::STRIDE_W-1:0] ds);
    int         rank;
    int         d;
    bit         done;
    logic [65:0] soff, doff, iw, sw, dw;
    addr_pair_t p;
    if (func == stcag_pkg::FUNC_DESC) begin
      extent_tab[dim]     = ext;
      src_stride_tab[dim] = ss;
      dst_stride_tab[dim] = ds;
    end else begin
      rank = rank_used();
      soff = '0;
      doff = '0;
      for (d = 0; d < rank; d++) begin
        iw   = 66'(walk_idx[d]);
        sw   = 66'(src_stride_tab[d]);
        dw   = 66'(dst_stride_tab[d]);
        soff = soff + iw * sw;
        doff = doff + iw * dw;
      end
      soff  = (soff << esize_reg) + 66'(src_base_reg);
      doff  = (doff << esize_reg) + 66'(dst_base_reg);
      p.src = soff[ADDR_W-1:0];
      p.dst = doff[ADDR_W-1:0];
      p.ovf = (|soff[65:ADDR_W]) | (|doff[65:ADDR_W]);
      p.last = 1'b1;
      for (d = 0; d < rank; d++)
        if (!at_final(d)) p.last = 1'b0;
      if (p.last) begin
        for (d = 0; d < MAX_RANK; d++) walk_idx[d] = '0;
      end else begin
        d    = rank - 1;
        done = 1'b0;
        while (!done && d >= 0) begin
          if (at_final(d)) begin
            walk_idx[d] = '0;
          end else begin
            walk_idx[d] = walk_idx[d] + 1'b1;
            done = 1'b1;
          end
          d--;
        end
      end
      pending_pairs.push_back(p);
    end
  endtask

  task automatic send_beat(input logic func, input logic [stcag_pkg::DIM_W-1:0] dim,
                           input logic [EXT_W-1:0] ext,
                           input logic [stcag_pkg::STRIDE_W-1:0] ss,
                           input logic [stcag_pkg::STRIDE_W-1:0] ds);
    int gap;
    in_valid      <= 1'b1;
    in_func       <= func;
    in_dim_index  <= dim;
    in_extent     <= ext;
    in_src_stride <= ss;
    in_dst_stride <= ds;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_beat(func, dim, ext, ss, ds);
    beats_sent++;
    gap = gap_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic step_beat();
    send_beat(stcag_pkg::FUNC_STEP, stcag_pkg::DIM_W'($urandom), EXT_W'($urandom),
              stcag_pkg::STRIDE_W'($urandom), stcag_pkg::STRIDE_W'($urandom));
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [stcag_pkg::CFG_IDX_W-1:0] idx,
                          input logic [ADDR_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // writes all four registers; unused upper data bits carry junk
  task automatic set_config(input logic [stcag_pkg::RANK_W-1:0] rank,
                            input logic [stcag_pkg::ESIZE_W-1:0] esize,
                            input logic [ADDR_W-1:0] sbase, input logic [ADDR_W-1:0] dbase);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_beat(stcag_pkg::CFG_ACTIVE_RANK, {junk[47:4], rank});
    cfg_beat(stcag_pkg::CFG_ELEM_SIZE_LOG2, {junk[47:2], esize});
    cfg_beat(stcag_pkg::CFG_SRC_BASE, sbase);
    cfg_beat(stcag_pkg::CFG_DST_BASE, dbase);
    cfg_we       <= 1'b0;
    rank_reg     = rank;
    esize_reg    = esize;
    src_base_reg = sbase;
    dst_base_reg = dbase;
  endtask

  task automatic test_reset_state();
    step_beat();
    step_beat();
    wait_idle();
  endtask

  task automatic test_field_extremes();
    set_config(4'd2, 2'd3, '1, '0);
    send_beat(stcag_pkg::FUNC_DESC, 3'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send_beat(stcag_pkg::FUNC_DESC, 3'd1, 16'd2, 32'd1, 32'hFFFF_FFFF);
    repeat (3) step_beat();
    wait_idle();
  endtask

  task automatic test_rank_limits();
    set_config(4'd0, 2'd0, 48'h1000, 48'h2000);
    step_beat();
    wait_idle();
    set_config(4'd15, 2'd1, 48'h0, 48'hFFFF_FFFF_0000);
    step_beat();
    step_beat();
    wait_idle();
    set_config(4'd9, 2'd2, 48'h0, 48'h0);
    step_beat();
    wait_idle();
  endtask

  task automatic test_zero_extent();
    set_config(4'd1, 2'd2, 48'h40, 48'h80);
    send_beat(stcag_pkg::FUNC_DESC, 3'd0, 16'd0, 32'd5, 32'd9);
    step_beat();
    step_beat();
    wait_idle();
  endtask

  task automatic test_midwalk_descriptor();
    set_config(4'd1, 2'd0, 48'h0, 48'h100);
    send_beat(stcag_pkg::FUNC_DESC, 3'd0, 16'd5, 32'd3, 32'd7);
    repeat (3) step_beat();
    // counter now sits past the new final index
    send_beat(stcag_pkg::FUNC_DESC, 3'd0, 16'd2, 32'd3, 32'd7);
    step_beat();
    step_beat();
    wait_idle();
  endtask

  task automatic test_random_walks();
    int               start, rank, prod, eff, steps, d, k;
    logic [EXT_W-1:0] ext;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      wait_idle();
      gap_en   = ($urandom_range(0, 4) != 0);
      stall_en = ($urandom_range(0, 4) != 0);
      set_config(pick_rank(), stcag_pkg::ESIZE_W'($urandom_range(0, 3)), pick_addr(),
                 pick_addr());
      rank = rank_used();
      prod = 1;
      for (d = 0; d < rank; d++) begin
        ext = EXT_W'($urandom_range(0, 4));
        eff = (ext == 0) ? 1 : int'(ext);
        if (prod * eff > WALK_BUDGET) begin
          ext = 16'd1;
          eff = 1;
        end
        prod = prod * eff;
        send_beat(stcag_pkg::FUNC_DESC, stcag_pkg::DIM_W'(d), ext, pick_stride(),
                  pick_stride());
      end
      steps = prod + $urandom_range(0, 3);
      for (k = 0; k < steps; k++) begin
        if ($urandom_range(0, 24) == 0) begin
          ext = $urandom_range(0, 1) ? EXT_W'($urandom) : EXT_W'($urandom_range(0, 6));
          send_beat(stcag_pkg::FUNC_DESC, stcag_pkg::DIM_W'($urandom), ext, pick_stride(),
                    pick_stride());
        end
        if (k == steps / 2 && $urandom_range(0, 7) == 0) hold_until_drained();
        step_beat();
      end
    end
    gap_en   = 1'b1;
    stall_en = 1'b1;
    wait_idle();
  endtask

  // receiver stall bursts
  always @(posedge clk) begin : stall_gen
    int hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      hold = stall_en ? pick_gap() : 0;
      out_stall  <= (hold != 0);
      stall_left <= (hold != 0) ? hold - 1 : 0;
    end
  end

  task automatic report_field(input string name, input logic [ADDR_W-1:0] exp_v,
                              input logic [ADDR_W-1:0] act_v);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    fails++;
  endtask

  always @(posedge clk) begin : check_pair
    addr_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual src %h dst %h", $time,
                 out_src_addr, out_dst_addr);
        fails++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_src_addr !== want.src) report_field("src_addr", want.src, out_src_addr);
        if (out_dst_addr !== want.dst) report_field("dst_addr", want.dst, out_dst_addr);
        if (out_last !== want.last)
          report_field("last", ADDR_W'(want.last), ADDR_W'(out_last));
        if (out_overflow !== want.ovf)
          report_field("overflow", ADDR_W'(want.ovf), ADDR_W'(out_overflow));
      end
    end
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_field_extremes();
    test_rank_limits();
    test_zero_extent();
    test_midwalk_descriptor();
    test_random_walks();
    if (pending_pairs.size() != 0) begin
      $display("%0t: %0d address pairs never arrived", $time, pending_pairs.size());
      fails++;
    end
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
